// ===== hdl/ils_pkg.sv =====
// Shared types and constants for the integer literal scanner.
`default_nettype none

package ils_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int CHAR_W      = 8;
    localparam int LENGTH_W    = 8;
    localparam int RADIX_W     = 2;
    localparam int DIGIT_W     = 4;

    localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd1;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd2;

    // One character after classification, as the back end consumes it.
    typedef struct packed {
        logic               eoi;
        logic               is_zero;
        logic               is_oct;
        logic               is_dec;
        logic               is_hex;
        logic               is_lower_x;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

endpackage

`default_nettype wire

// ===== hdl/ils_front.sv =====
// Front end: accepts characters and registers their classification.
`default_nettype none

module ils_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [ils_pkg::CHAR_W-1:0] ch,
    input  wire logic                      end_of_input,
    output logic                           cls_valid,
    input  wire logic                      cls_ready,
    output ils_pkg::char_class_t           cls_data
);

    localparam logic [ils_pkg::CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [ils_pkg::CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [ils_pkg::CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [ils_pkg::CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [ils_pkg::CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [ils_pkg::CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [ils_pkg::CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [ils_pkg::CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [ils_pkg::CHAR_W-1:0] TEN      = 8'd10;

    logic                 valid_reg;
    logic                 valid_next;
    ils_pkg::char_class_t data_reg;
    ils_pkg::char_class_t cls_now;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 is_upper;
    logic                 is_lower;
    logic [ils_pkg::CHAR_W-1:0] digit_wide;

    always_comb
    begin
        is_upper = (ch >= CH_UP_A) && (ch <= CH_UP_F);
        is_lower = (ch >= CH_LO_A) && (ch <= CH_LO_F);
        if (is_upper)
        begin
            digit_wide = ch - CH_UP_A + TEN;
        end
        else if (is_lower)
        begin
            digit_wide = ch - CH_LO_A + TEN;
        end
        else
        begin
            digit_wide = ch - CH_0;
        end
        cls_now.eoi        = end_of_input;
        cls_now.is_zero    = (ch == CH_0);
        cls_now.is_oct     = (ch >= CH_0) && (ch <= CH_7);
        cls_now.is_dec     = (ch >= CH_0) && (ch <= CH_9);
        cls_now.is_hex     = cls_now.is_dec || is_upper || is_lower;
        cls_now.is_lower_x = (ch == CH_LO_X);
        cls_now.digit      = digit_wide[ils_pkg::DIGIT_W-1:0];
    end

    assign out_xfer = valid_reg && cls_ready;
    assign full     = valid_reg && !cls_ready;
    assign in_xfer  = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_xfer)
        begin
            valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            data_reg <= cls_now;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/ils_queue.sv =====
// Short queue of classified characters between front and back end.
`default_nettype none

module ils_queue
#(
    parameter int DEPTH = ils_pkg::QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    input  wire ils_pkg::char_class_t wr_data,
    output logic                      rd_valid,
    input  wire logic                 rd_ready,
    output ils_pkg::char_class_t      rd_data
);

    // DEPTH is a power of two of at least 2, so the pointers wrap on their own.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ils_pkg::char_class_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ils_back.sv =====
// Back end: literal scan state, value accumulation and result register.
`default_nettype none

module ils_back
#(
    parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cls_valid,
    output logic                               cls_ready,
    input  wire ils_pkg::char_class_t          cls_data,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [VALUE_WIDTH-1:0]             value,
    output logic [ils_pkg::LENGTH_W-1:0]       length,
    output logic [ils_pkg::RADIX_W-1:0]        radix_code
);

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ZERO = 3'd1;
    localparam logic [2:0] MODE_DEC  = 3'd2;
    localparam logic [2:0] MODE_OCT  = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;

    localparam logic [ils_pkg::LENGTH_W-1:0] LEN_MAX = '1;
    localparam logic [ils_pkg::LENGTH_W-1:0] LEN_ONE = ils_pkg::LENGTH_W'(1);

    logic [2:0]                      mode_reg;
    logic [2:0]                      mode_next;
    logic [VALUE_WIDTH-1:0]          acc_reg;
    logic [VALUE_WIDTH-1:0]          acc_next;
    logic [ils_pkg::LENGTH_W-1:0]    cnt_reg;
    logic [ils_pkg::LENGTH_W-1:0]    cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [VALUE_WIDTH-1:0]          out_value_reg;
    logic [ils_pkg::LENGTH_W-1:0]    out_length_reg;
    logic [ils_pkg::RADIX_W-1:0]     out_radix_reg;

    logic                            step;
    logic                            emit;
    logic [VALUE_WIDTH-1:0]          digit_ext;
    logic [VALUE_WIDTH-1:0]          acc_dec;
    logic [VALUE_WIDTH-1:0]          acc_oct;
    logic [VALUE_WIDTH-1:0]          acc_hex;
    logic [ils_pkg::LENGTH_W-1:0]    cnt_inc;
    logic [ils_pkg::RADIX_W-1:0]     radix_now;
    logic [2:0]                      start_mode;
    logic [VALUE_WIDTH-1:0]          start_acc;
    logic [ils_pkg::LENGTH_W-1:0]    start_cnt;

    // Advance one character whenever the result register is free or draining.
    assign step      = cls_valid && (!out_valid_reg || pop);
    assign cls_ready = !out_valid_reg || pop;

    assign digit_ext = {{(VALUE_WIDTH - ils_pkg::DIGIT_W){1'b0}}, cls_data.digit};
    assign acc_dec   = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
    assign acc_oct   = (acc_reg << 3) + digit_ext;
    assign acc_hex   = (acc_reg << 4) + digit_ext;
    assign cnt_inc   = (cnt_reg == LEN_MAX) ? cnt_reg : cnt_reg + 1'b1;

    always_comb
    begin
        case (mode_reg)
            MODE_OCT: radix_now = ils_pkg::RADIX_OCT;
            MODE_HEX: radix_now = ils_pkg::RADIX_HEX;
            default:  radix_now = ils_pkg::RADIX_DEC;
        endcase
    end

    // Restart from the current character once a literal has ended.
    always_comb
    begin
        start_mode = MODE_IDLE;
        start_acc  = '0;
        start_cnt  = '0;
        if (cls_data.is_zero)
        begin
            start_mode = MODE_ZERO;
            start_cnt  = LEN_ONE;
        end
        else if (cls_data.is_dec)
        begin
            start_mode = MODE_DEC;
            start_acc  = digit_ext;
            start_cnt  = LEN_ONE;
        end
    end

    always_comb
    begin
        emit      = 1'b0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        if (cls_data.eoi)
        begin
            emit      = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_ZERO:
                begin
                    if (cls_data.is_oct)
                    begin
                        mode_next = MODE_OCT;
                        acc_next  = acc_oct;
                        cnt_next  = cnt_inc;
                    end
                    else if (cls_data.is_lower_x)
                    begin
                        mode_next = MODE_HEX;
                        cnt_next  = cnt_inc;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                MODE_DEC:
                begin
                    if (cls_data.is_dec)
                    begin
                        acc_next = acc_dec;
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                MODE_OCT:
                begin
                    if (cls_data.is_oct)
                    begin
                        acc_next = acc_oct;
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                MODE_HEX:
                begin
                    if (cls_data.is_hex)
                    begin
                        acc_next = acc_hex;
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = start_mode;
                    acc_next  = start_acc;
                    cnt_next  = start_cnt;
                end
            endcase
            if (emit)
            begin
                mode_next = start_mode;
                acc_next  = start_acc;
                cnt_next  = start_cnt;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_value_reg  <= acc_reg;
            out_length_reg <= cnt_reg;
            out_radix_reg  <= radix_now;
        end
    end

    assign empty      = !out_valid_reg;
    assign value      = out_value_reg;
    assign length     = out_length_reg;
    assign radix_code = out_radix_reg;

endmodule

`default_nettype wire

// ===== hdl/integer_literal_scanner.sv =====
// Top level of the integer literal scanner.
`default_nettype none

// Scans a byte stream for C-style integer literals, one character per
// transfer. A '0' followed by 0-7 opens an octal literal, "0x" a hex literal
// (digits 0-9, a-f, A-F), a lone '0' is a complete literal of value 0, and
// 1-9 opens a decimal literal. The first character that does not belong ends
// the literal and yields one result (value modulo 2^VALUE_WIDTH, length
// including prefix and saturating at 255, radix code 0 dec / 1 oct / 2 hex);
// that same character may then open the next literal. A transfer with
// end_of_input high flushes a pending literal and ignores ch. Both sides look
// like queues: push/full in, empty/pop out. The block takes one character
// per clock cycle sustained while results are popped as they appear; the
// scan state updates once per cycle with a shift-and-add for the radix
// multiply. A character passes the front register, the classified-character
// queue (QUEUE_DEPTH entries) and the scan stage, which registers the result
// when it accepts the character ending its literal. The back end stalls only
// while the result register is held by an un-popped result.
module integer_literal_scanner
#(
    parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH,
    parameter int QUEUE_DEPTH = ils_pkg::QUEUE_DEPTH
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [ils_pkg::CHAR_W-1:0]   ch,
    input  wire logic                         end_of_input,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [VALUE_WIDTH-1:0]            value,
    output logic [ils_pkg::LENGTH_W-1:0]      length,
    output logic [ils_pkg::RADIX_W-1:0]       radix_code
);

    // Front register to queue.
    logic                 front_valid;
    logic                 front_ready;
    ils_pkg::char_class_t front_data;

    // Queue to scan stage.
    logic                 back_valid;
    logic                 back_ready;
    ils_pkg::char_class_t back_data;

    ils_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .ch           (ch),
        .end_of_input (end_of_input),
        .cls_valid    (front_valid),
        .cls_ready    (front_ready),
        .cls_data     (front_data)
    );

    ils_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_data),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_data)
    );

    ils_back
    #(
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cls_valid  (back_valid),
        .cls_ready  (back_ready),
        .cls_data   (back_data),
        .empty      (empty),
        .pop        (pop),
        .value      (value),
        .length     (length),
        .radix_code (radix_code)
    );

endmodule

`default_nettype wire
